### rtl/mrod_pkg.sv
package mrod_pkg;

  localparam int unsigned DigestW = 256;
  localparam int unsigned BlockW  = 512;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_LEAF_TXT,
    ST_LEAF_PAD,
    ST_RED_CHK,
    ST_RD_L,
    ST_HASH_L,
    ST_RD_R,
    ST_HASH_R,
    ST_HASH_P,
    ST_ROOT,
    ST_OUT
  } mrod_state_e;

  // Command from the sequencer to the compression unit.
  typedef struct packed {
    logic start;
    logic first;  // begin a new message from the initial hash value
  } sha_cmd_t;

  localparam logic [1:0] WordLast = 2'd3;

  localparam logic [31:0] ShaIv [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam logic [31:0] ShaK [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  // Lowercase hex text of a 256-bit digest, most significant nibble first.
  function automatic logic [BlockW-1:0] hex_block(input logic [DigestW-1:0] d);
    logic [BlockW-1:0] b;
    logic [3:0] nib;
    b = '0;
    for (int j = 0; j < 64; j++) begin
      nib = d[DigestW-1-4*j -: 4];
      b[BlockW-1-8*j -: 8] = (nib < 4'd10) ? (8'h30 + {4'h0, nib}) : (8'h57 + {4'h0, nib});
    end
    return b;
  endfunction

  // Final padding block for a message of 64 bytes (leaf) or 128 bytes (parent).
  function automatic logic [BlockW-1:0] pad_block(input logic parent);
    logic [BlockW-1:0] b;
    b = '0;
    b[BlockW-1 -: 8] = 8'h80;
    b[31:0] = parent ? 32'd1024 : 32'd512;
    return b;
  endfunction

endpackage

### rtl/merkle_root_over_digests_core.sv
// Operation: words 0..2 of a digest are stored as they arrive. Word 3 hashes a leaf in two
// compressions; a parent takes three compressions plus one level check and two memory reads.
// All of it runs on one SHA-256 round unit.
// Throughput: one input transaction at a time; input ready drops during hashing and the
// reduction, and the four root words then leave one per accepted output transaction.
// Reset (rst_ni, asynchronous, active low) clears the sequencer, leaf count, overflow
// flag and expected root; the leaf memory needs no clearing pass.
module merkle_root_over_digests_core #(
  parameter int unsigned MAX_LEAVES = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [63:0] digest_word_i,
  input  logic [1:0]  word_index_i,
  input  logic        last_leaf_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [63:0] root_word_o,
  output logic [1:0]  out_word_index_o,
  output logic [2:0]  level_count_o,
  output logic        root_matches_o,
  output logic        leaves_dropped_o,
  output logic        last_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [7:0]  cfg_index_i,
  input  logic [63:0] cfg_data_i
);
  import mrod_pkg::*;

  localparam int unsigned AW = (MAX_LEAVES > 1) ? $clog2(MAX_LEAVES) : 1;
  localparam int unsigned CW = $clog2(MAX_LEAVES + 1);
  localparam logic [CW-1:0] MaxLeaves = CW'(MAX_LEAVES);

  mrod_state_e state_q, state_d;

  logic [63:0]        expected_q [4];
  logic [63:0]        pend_q [3];
  logic [CW-1:0]      count_q, n_q, i_q;
  logic               overflow_q, last_q, match_q;
  logic [2:0]         levels_q;
  logic [1:0]         k_q;
  logic [DigestW-1:0] root_q;

  logic               in_acc, out_acc, word3_acc;
  sha_cmd_t           cmd;
  logic [BlockW-1:0]  block;
  logic               sha_done;
  logic [DigestW-1:0] sha_digest;
  logic               ram_we, ram_re;
  logic [AW-1:0]      ram_waddr, ram_raddr;
  logic [DigestW-1:0] ram_rdata;
  logic [CW-1:0]      right_idx;
  logic               level_end;

  assign in_acc    = in_valid_i && in_ready_o;
  assign out_acc   = out_valid_o && out_ready_i;
  assign word3_acc = in_acc && (word_index_i == WordLast);
  assign cfg_ready_o = 1'b1;

  // Right child is the left one again when the level has an odd node at its end.
  assign right_idx = ((i_q + CW'(1)) < n_q) ? (i_q + CW'(1)) : i_q;
  assign level_end = (CW + 1)'(i_q) + (CW + 1)'(2) >= (CW + 1)'(n_q);

  // Next-state logic.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (word3_acc) begin
          if (count_q < MaxLeaves) begin
            state_d = ST_LEAF_TXT;
          end else if (last_leaf_i) begin
            state_d = ST_RED_CHK;
          end
        end
      end
      ST_LEAF_TXT: if (sha_done) state_d = ST_LEAF_PAD;
      ST_LEAF_PAD: if (sha_done) state_d = last_q ? ST_RED_CHK : ST_IDLE;
      ST_RED_CHK:  state_d = (n_q <= CW'(1)) ? ST_ROOT : ST_RD_L;
      ST_RD_L:     state_d = ST_HASH_L;
      ST_HASH_L:   if (sha_done) state_d = ST_RD_R;
      ST_RD_R:     state_d = ST_HASH_R;
      ST_HASH_R:   if (sha_done) state_d = ST_HASH_P;
      ST_HASH_P:   if (sha_done) state_d = ST_RED_CHK;
      ST_ROOT:     state_d = ST_OUT;
      ST_OUT:      if (out_acc && (k_q == WordLast)) state_d = ST_IDLE;
      default:     state_d = ST_IDLE;
    endcase
  end

  // Output and datapath control for each state.
  always_comb begin
    in_ready_o  = 1'b0;
    out_valid_o = 1'b0;
    cmd         = '0;
    block       = '0;
    ram_we      = 1'b0;
    ram_waddr   = '0;
    ram_re      = 1'b0;
    ram_raddr   = '0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        block = hex_block({pend_q[0], pend_q[1], pend_q[2], digest_word_i});
        if (word3_acc && (count_q < MaxLeaves)) begin
          cmd.start = 1'b1;
          cmd.first = 1'b1;
        end
      end
      ST_LEAF_TXT: begin
        block = pad_block(1'b0);
        cmd.start = sha_done;
      end
      ST_LEAF_PAD: begin
        ram_we    = sha_done;
        ram_waddr = count_q[AW-1:0];
      end
      ST_RED_CHK: begin
        ram_re    = 1'b1;
        ram_raddr = (n_q <= CW'(1)) ? '0 : i_q[AW-1:0];
      end
      ST_RD_L: begin
        block = hex_block(ram_rdata);
        cmd.start = 1'b1;
        cmd.first = 1'b1;
      end
      ST_HASH_L: begin
        ram_re    = sha_done;
        ram_raddr = right_idx[AW-1:0];
      end
      ST_RD_R: begin
        block = hex_block(ram_rdata);
        cmd.start = 1'b1;
      end
      ST_HASH_R: begin
        block = pad_block(1'b1);
        cmd.start = sha_done;
      end
      ST_HASH_P: begin
        ram_we    = sha_done;
        ram_waddr = AW'(i_q >> 1);
      end
      ST_ROOT: ;
      ST_OUT:  out_valid_o = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      count_q    <= '0;
      overflow_q <= 1'b0;
      last_q     <= 1'b0;
      n_q        <= '0;
      i_q        <= '0;
      levels_q   <= '0;
      k_q        <= '0;
      for (int r = 0; r < 4; r++) begin
        expected_q[r] <= '0;
      end
    end else begin
      state_q <= state_d;
      if (cfg_valid_i && (cfg_index_i < 8'd4)) begin
        expected_q[cfg_index_i[1:0]] <= cfg_data_i;
      end
      if (state_q == ST_IDLE && word3_acc) begin
        last_q <= last_leaf_i;
        i_q    <= '0;
        levels_q <= '0;
        n_q    <= count_q;
        if (count_q >= MaxLeaves) begin
          overflow_q <= 1'b1;
        end
      end
      if (state_q == ST_LEAF_PAD && sha_done) begin
        count_q <= count_q + CW'(1);
        n_q     <= count_q + CW'(1);
      end
      if (state_q == ST_HASH_P && sha_done) begin
        if (level_end) begin
          i_q <= '0;
          n_q <= CW'(((CW + 1)'(n_q) + (CW + 1)'(1)) >> 1);
          if (levels_q != 3'd7) begin
            levels_q <= levels_q + 3'd1;
          end
        end else begin
          i_q <= i_q + CW'(2);
        end
      end
      if (out_acc) begin
        k_q <= k_q + 2'd1;
        if (k_q == WordLast) begin
          count_q    <= '0;
          overflow_q <= 1'b0;
        end
      end
    end
  end

  // Payload registers: pending digest words and the captured root.
  always_ff @(posedge clk_i) begin
    if (in_acc && (word_index_i != WordLast)) begin
      pend_q[word_index_i] <= digest_word_i;
    end
    if (state_q == ST_ROOT) begin
      root_q  <= ram_rdata;
      match_q <= ram_rdata == {expected_q[0], expected_q[1], expected_q[2], expected_q[3]};
    end
  end

  mrod_sha_core u_sha (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cmd_i    (cmd),
    .block_i  (block),
    .done_o   (sha_done),
    .digest_o (sha_digest)
  );

  mrod_ram #(
    .WIDTH (DigestW),
    .DEPTH (MAX_LEAVES)
  ) u_leaf_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (sha_digest),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign root_word_o      = root_q[DigestW-1-64*k_q -: 64];
  assign out_word_index_o = k_q;
  assign level_count_o    = levels_q;
  assign root_matches_o   = match_q;
  assign leaves_dropped_o = overflow_q;
  assign last_o           = (k_q == WordLast);

  assert property (@(posedge clk_i) disable iff (!rst_ni) out_valid_o |-> !in_ready_o)
    else $error("input accepted while root words are pending");
  assert property (@(posedge clk_i) disable iff (!rst_ni) count_q <= MaxLeaves)
    else $error("leaf count beyond capacity");
  assert property (@(posedge clk_i) disable iff (!rst_ni) out_acc && last_o |=> !out_valid_o)
    else $error("root words continue after the last one");
  assert property (@(posedge clk_i) disable iff (!rst_ni) ram_we |-> !ram_re)
    else $error("leaf memory read and written in one cycle");

endmodule

### rtl/mrod_ram.sv
module mrod_ram #(
  parameter int unsigned WIDTH = 256,
  parameter int unsigned DEPTH = 32
) (
  input  logic                                      clk_i,
  input  logic                                      we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                          wdata_i,
  input  logic                                      re_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                          rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

### rtl/mrod_sha_core.sv
module mrod_sha_core (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  mrod_pkg::sha_cmd_t        cmd_i,
  input  logic [mrod_pkg::BlockW-1:0] block_i,
  output logic                      done_o,
  output logic [mrod_pkg::DigestW-1:0] digest_o
);
  import mrod_pkg::*;

  logic [31:0] hv_q [8];
  logic [31:0] wv_q [8];
  logic [31:0] wv_d [8];
  logic [31:0] w_q  [16];
  logic [5:0]  round_q;
  logic        busy_q, fin_q, done_q;
  logic [31:0] t1, t2, s0, s1, sig0, sig1, ch, maj, w_new;

  function automatic logic [31:0] rotr(input logic [31:0] x, input int unsigned n);
    return (x >> n) | (x << (32 - n));
  endfunction

  always_comb begin
    sig1 = rotr(wv_q[4], 6) ^ rotr(wv_q[4], 11) ^ rotr(wv_q[4], 25);
    ch   = (wv_q[4] & wv_q[5]) ^ (~wv_q[4] & wv_q[6]);
    sig0 = rotr(wv_q[0], 2) ^ rotr(wv_q[0], 13) ^ rotr(wv_q[0], 22);
    maj  = (wv_q[0] & wv_q[1]) ^ (wv_q[0] & wv_q[2]) ^ (wv_q[1] & wv_q[2]);
    t1   = wv_q[7] + sig1 + ch + ShaK[round_q] + w_q[0];
    t2   = sig0 + maj;
    s0   = rotr(w_q[1], 7) ^ rotr(w_q[1], 18) ^ (w_q[1] >> 3);
    s1   = rotr(w_q[14], 17) ^ rotr(w_q[14], 19) ^ (w_q[14] >> 10);
    w_new = s1 + w_q[9] + s0 + w_q[0];
    wv_d[0] = t1 + t2;
    wv_d[1] = wv_q[0];
    wv_d[2] = wv_q[1];
    wv_d[3] = wv_q[2];
    wv_d[4] = wv_q[3] + t1;
    wv_d[5] = wv_q[4];
    wv_d[6] = wv_q[5];
    wv_d[7] = wv_q[6];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q  <= 1'b0;
      fin_q   <= 1'b0;
      done_q  <= 1'b0;
      round_q <= '0;
      for (int i = 0; i < 8; i++) begin
        hv_q[i] <= ShaIv[i];
      end
    end else begin
      done_q <= 1'b0;
      fin_q  <= 1'b0;
      if (cmd_i.start) begin
        busy_q  <= 1'b1;
        round_q <= '0;
        if (cmd_i.first) begin
          for (int i = 0; i < 8; i++) begin
            hv_q[i] <= ShaIv[i];
          end
        end
      end else if (busy_q) begin
        round_q <= round_q + 6'd1;
        if (round_q == 6'd63) begin
          busy_q <= 1'b0;
          fin_q  <= 1'b1;
        end
      end else if (fin_q) begin
        for (int i = 0; i < 8; i++) begin
          hv_q[i] <= hv_q[i] + wv_q[i];
        end
        done_q <= 1'b1;
      end
    end
  end

  // Working variables and message schedule are payload only.
  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      for (int i = 0; i < 8; i++) begin
        wv_q[i] <= cmd_i.first ? ShaIv[i] : hv_q[i];
      end
      for (int i = 0; i < 16; i++) begin
        w_q[i] <= block_i[BlockW-1-32*i -: 32];
      end
    end else if (busy_q) begin
      wv_q <= wv_d;
      for (int i = 0; i < 15; i++) begin
        w_q[i] <= w_q[i+1];
      end
      w_q[15] <= w_new;
    end
  end

  assign done_o = done_q;
  always_comb begin
    for (int i = 0; i < 8; i++) begin
      digest_o[DigestW-1-32*i -: 32] = hv_q[i];
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni) cmd_i.start |-> !busy_q && !fin_q)
    else $error("compression started while busy");
  assert property (@(posedge clk_i) disable iff (!rst_ni) fin_q |=> done_q)
    else $error("final add not followed by done");
  assert property (@(posedge clk_i) disable iff (!rst_ni) busy_q |-> !fin_q && !done_q)
    else $error("round loop overlaps completion");

endmodule

### verif/root_checker.sv
module root_checker #(
  parameter int unsigned MAX_LEAVES = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_ready_i,
  input  logic [63:0] digest_word_i,
  input  logic [1:0]  word_index_i,
  input  logic        last_leaf_i,
  input  logic        out_valid_i,
  input  logic        out_ready_i,
  input  logic [63:0] root_word_i,
  input  logic [1:0]  out_word_index_i,
  input  logic [2:0]  level_count_i,
  input  logic        root_matches_i,
  input  logic        leaves_dropped_i,
  input  logic        last_i,
  input  logic        cfg_valid_i,
  input  logic        cfg_ready_i,
  input  logic [7:0]  cfg_index_i,
  input  logic [63:0] cfg_data_i,
  output int          fail_count_o,
  output int          roots_owed_o
);

  localparam int unsigned NumRootRegs = 4;

  typedef struct packed {
    logic [63:0] word;
    logic [1:0]  index;
    logic [2:0]  levels;
    logic        match_flag;
    logic        dropped;
    logic        last;
  } root_word_t;

  root_word_t  owed_q[$];
  logic [63:0] ref_root[NumRootRegs];
  logic [63:0] digest_part[3];
  logic [255:0] leaf_mem[MAX_LEAVES];
  int unsigned leaf_cnt;
  bit          overflow;

  function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
    return (x >> n) | (x << (32 - n));
  endfunction

  // One SHA-256 compression of a 512-bit block onto chaining value hv.
  function automatic logic [255:0] compress(input logic [255:0] hv, input logic [511:0] blk);
    logic [31:0] w[64];
    logic [31:0] v[8];
    logic [31:0] t1, t2;
    logic [255:0] res;
    for (int t = 0; t < 16; t++) w[t] = blk[511-32*t -: 32];
    for (int t = 16; t < 64; t++) begin
      w[t] = (rotr(w[t-2], 17) ^ rotr(w[t-2], 19) ^ (w[t-2] >> 10)) + w[t-7] +
             (rotr(w[t-15], 7) ^ rotr(w[t-15], 18) ^ (w[t-15] >> 3)) + w[t-16];
    end
    for (int i = 0; i < 8; i++) v[i] = hv[255-32*i -: 32];
    for (int t = 0; t < 64; t++) begin
      t1 = v[7] + (rotr(v[4], 6) ^ rotr(v[4], 11) ^ rotr(v[4], 25)) +
           ((v[4] & v[5]) ^ (~v[4] & v[6])) + mrod_pkg::ShaK[t] + w[t];
      t2 = (rotr(v[0], 2) ^ rotr(v[0], 13) ^ rotr(v[0], 22)) +
           ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
      v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
      v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
    end
    for (int i = 0; i < 8; i++) res[255-32*i -: 32] = hv[255-32*i -: 32] + v[i];
    return res;
  endfunction

  // Lowercase ASCII hex of a 256-bit value, first character in the top byte.
  function automatic logic [511:0] as_hex(input logic [255:0] d);
    logic [511:0] txt;
    logic [3:0] nib;
    for (int j = 0; j < 64; j++) begin
      nib = d[255-4*j -: 4];
      txt[511-8*j -: 8] = (nib < 10) ? 8'd48 + nib : 8'd87 + nib;
    end
    return txt;
  endfunction

  function automatic logic [255:0] sha_iv();
    logic [255:0] iv;
    for (int i = 0; i < 8; i++) iv[255-32*i -: 32] = mrod_pkg::ShaIv[i];
    return iv;
  endfunction

  function automatic logic [511:0] tail_block(input logic [63:0] bit_len);
    return {8'h80, 440'd0, bit_len};
  endfunction

  function automatic logic [255:0] leaf_hash(input logic [255:0] d);
    return compress(compress(sha_iv(), as_hex(d)), tail_block(64'd512));
  endfunction

  function automatic logic [255:0] parent_hash(input logic [255:0] l, input logic [255:0] r);
    return compress(compress(compress(sha_iv(), as_hex(l)), as_hex(r)), tail_block(64'd1024));
  endfunction

  // Folds the stored leaves into a root and queues its four words.
  task automatic reduce_set();
    int unsigned n, lv, rt;
    logic [255:0] root;
    bit hit;
    root_word_t rw;
    n = leaf_cnt;
    lv = 0;
    while (n > 1) begin
      for (int unsigned i = 0; i < n; i += 2) begin
        rt = (i + 1 < n) ? i + 1 : i;
        leaf_mem[i/2] = parent_hash(leaf_mem[i], leaf_mem[rt]);
      end
      n = (n + 1) / 2;
      lv++;
    end
    if (lv > 7) lv = 7;
    root = leaf_mem[0];
    hit = 1'b1;
    for (int k = 0; k < 4; k++) if (root[255-64*k -: 64] != ref_root[k]) hit = 1'b0;
    for (int k = 0; k < 4; k++) begin
      rw.word       = root[255-64*k -: 64];
      rw.index      = k[1:0];
      rw.levels     = lv[2:0];
      rw.match_flag = hit;
      rw.dropped    = overflow;
      rw.last       = (k == 3);
      owed_q = {owed_q, rw};
    end
    leaf_cnt = 0;
    overflow = 1'b0;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    root_word_t want;
    if (!rst_ni) begin
      owed_q.delete();
      for (int i = 0; i < NumRootRegs; i++) ref_root[i] = '0;
      leaf_cnt = 0;
      overflow = 1'b0;
      fail_count_o = 0;
      roots_owed_o = 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i && cfg_index_i < NumRootRegs)
        ref_root[cfg_index_i[1:0]] = cfg_data_i;
      if (in_valid_i && in_ready_i) begin
        if (word_index_i != mrod_pkg::WordLast) begin
          digest_part[word_index_i] = digest_word_i;
        end else begin
          if (leaf_cnt < MAX_LEAVES) begin
            leaf_mem[leaf_cnt] = leaf_hash({digest_part[0], digest_part[1],
                                            digest_part[2], digest_word_i});
            leaf_cnt++;
          end else begin
            overflow = 1'b1;
          end
          if (last_leaf_i) reduce_set();
        end
      end
      if (out_valid_i && out_ready_i) begin
        if (owed_q.size() == 0) begin
          $error("root word transaction with nothing expected: %h", root_word_i);
          fail_count_o++;
        end else begin
          want = owed_q.pop_front();
          if (root_word_i !== want.word) begin
            $error("root_word: expected %h, got %h", want.word, root_word_i);
            fail_count_o++;
          end
          if (out_word_index_i !== want.index) begin
            $error("out_word_index: expected %0d, got %0d", want.index, out_word_index_i);
            fail_count_o++;
          end
          if (level_count_i !== want.levels) begin
            $error("level_count: expected %0d, got %0d", want.levels, level_count_i);
            fail_count_o++;
          end
          if (root_matches_i !== want.match_flag) begin
            $error("root_matches: expected %0d, got %0d", want.match_flag, root_matches_i);
            fail_count_o++;
          end
          if (leaves_dropped_i !== want.dropped) begin
            $error("leaves_dropped: expected %0d, got %0d", want.dropped, leaves_dropped_i);
            fail_count_o++;
          end
          if (last_i !== want.last) begin
            $error("last: expected %0d, got %0d", want.last, last_i);
            fail_count_o++;
          end
        end
      end
      roots_owed_o = owed_q.size();
    end
  end

endmodule

### verif/testbench.sv
// Stimulus and verdict for the Merkle root core. Digests are sent as sets of four-word
// transactions; the checker beside the block predicts every root and compares it.
module testbench;

  localparam logic [7:0] RegRootW0 = 8'd0;
  localparam logic [7:0] RegRootW1 = 8'd1;
  localparam logic [7:0] RegRootW2 = 8'd2;
  localparam logic [7:0] RegRootW3 = 8'd3;
  localparam logic [7:0] RegNone   = 8'd4;   // first index past the root registers
  localparam logic [7:0] RegTop    = 8'd255;
  localparam int unsigned Capacity = 32;
  // A full 32-leaf reduction runs with no transaction, and the receiver may hold off
  // on top of that, so a quiet stretch well past both is a hang.
  localparam int unsigned QuietLimit = 40000;
  // Settling time before a register write: longer than one parent hash.
  localparam int unsigned SettleCycles = 300;
  // Length of the long receiver hold-off.
  localparam int unsigned HoldLen = 1500;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [63:0] digest_word = '0;
  logic [1:0]  word_index = '0;
  logic        last_leaf = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [63:0] root_word;
  logic [1:0]  out_word_index;
  logic [2:0]  level_count;
  logic        root_matches, leaves_dropped, last;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [7:0]  cfg_index = '0;
  logic [63:0] cfg_data = '0;
  int          fail_count, roots_owed;

  int unsigned send_idle_pct = 10;
  int unsigned recv_idle_pct = 47;
  int unsigned hold_req = 0;         // bumped by the stimulus to ask for a hold-off
  int unsigned hold_seen = 0;
  int unsigned hold_cycles = 0;      // pending receiver hold-off, counted below
  int unsigned quiet_cycles = 0;
  int unsigned sent_items = 0;
  logic [255:0] seen_root;           // last root observed on the output channel
  logic [255:0] prev_set[$];         // digests of the last in-order set, for replay

  always #5 clk_i = ~clk_i;

  merkle_root_over_digests_core #(.MAX_LEAVES(Capacity)) u_top (
    .clk_i, .rst_ni,
    .in_valid_i(in_valid), .in_ready_o(in_ready),
    .digest_word_i(digest_word), .word_index_i(word_index), .last_leaf_i(last_leaf),
    .out_valid_o(out_valid), .out_ready_i(out_ready),
    .root_word_o(root_word), .out_word_index_o(out_word_index),
    .level_count_o(level_count), .root_matches_o(root_matches),
    .leaves_dropped_o(leaves_dropped), .last_o(last),
    .cfg_valid_i(cfg_valid), .cfg_ready_o(cfg_ready),
    .cfg_index_i(cfg_index), .cfg_data_i(cfg_data)
  );

  root_checker #(.MAX_LEAVES(Capacity)) u_chk (
    .clk_i, .rst_ni,
    .in_valid_i(in_valid), .in_ready_i(in_ready),
    .digest_word_i(digest_word), .word_index_i(word_index), .last_leaf_i(last_leaf),
    .out_valid_i(out_valid), .out_ready_i(out_ready),
    .root_word_i(root_word), .out_word_index_i(out_word_index),
    .level_count_i(level_count), .root_matches_i(root_matches),
    .leaves_dropped_i(leaves_dropped), .last_i(last),
    .cfg_valid_i(cfg_valid), .cfg_ready_i(cfg_ready),
    .cfg_index_i(cfg_index), .cfg_data_i(cfg_data),
    .fail_count_o(fail_count), .roots_owed_o(roots_owed)
  );

  // Receiver: random stalls, plus a long hold-off when the stimulus asks for one. The
  // root words seen are kept so a later phase can program them as the expected root.
  always @(negedge clk_i) begin
    if (hold_req != hold_seen) begin
      hold_seen   <= hold_req;
      hold_cycles <= HoldLen;
      out_ready   <= 1'b0;
    end else if (hold_cycles > 0) begin
      out_ready <= 1'b0;
      hold_cycles <= hold_cycles - 1;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  always @(posedge clk_i) begin
    if (out_valid && out_ready) seen_root[255-64*out_word_index -: 64] <= root_word;
  end

  // Watchdog: any transaction on any channel counts as progress.
  always @(posedge clk_i) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
      quiet_cycles <= 0;
    else if (rst_ni)
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= QuietLimit) begin
      $display("testbench: done, errors");
      $finish;
    end
  end

  // Every task below starts and ends at a falling edge. Valid is only lowered when an
  // idle gap is taken or by drain, so it never drops and rises in the same time step.
  task automatic send_word(input logic [63:0] w, input logic [1:0] ix, input logic lf);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(3, 1)) @(negedge clk_i);
    end
    in_valid    <= 1'b1;
    digest_word <= w;
    word_index  <= ix;
    last_leaf   <= lf;
    do @(posedge clk_i); while (!in_ready);
    sent_items++;
    @(negedge clk_i);
  endtask

  task automatic send_digest(input logic [255:0] d, input logic lf);
    for (int k = 0; k < 4; k++) send_word(d[255-64*k -: 64], k[1:0], (k == 3) ? lf : 1'b0);
  endtask

  function automatic logic [255:0] random_digest();
    return {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
  endfunction

  // A set of n random digests sent in word order; it is remembered for a replay.
  task automatic send_set(input int unsigned n);
    logic [255:0] d;
    prev_set.delete();
    for (int unsigned i = 0; i < n; i++) begin
      d = random_digest();
      prev_set = {prev_set, d};
      send_digest(d, i == n - 1);
    end
  endtask

  // A scrambled digest: words 0..2 arrive in random order, some of them repeated or
  // carrying a stray last_leaf flag, which the block must ignore.
  task automatic send_scrambled(input logic lf);
    int unsigned extra;
    logic [1:0] ix;
    extra = $urandom_range(5, 3);
    for (int unsigned i = 0; i < extra; i++) begin
      ix = 2'($urandom_range(2));
      send_word({$urandom, $urandom}, ix, 1'($urandom_range(1)));
    end
    for (int k = 0; k < 3; k++) send_word({$urandom, $urandom}, k[1:0], 1'($urandom_range(1)));
    send_word({$urandom, $urandom}, mrod_pkg::WordLast, lf);
  endtask

  task automatic write_reg(input logic [7:0] ix, input logic [63:0] v);
    cfg_valid <= 1'b1;
    cfg_index <= ix;
    cfg_data  <= v;
    do @(posedge clk_i); while (!cfg_ready);
    @(negedge clk_i);
    cfg_valid <= 1'b0;
    @(negedge clk_i);
  endtask

  task automatic write_root(input logic [255:0] r);
    write_reg(RegRootW0, r[255:192]);
    write_reg(RegRootW1, r[191:128]);
    write_reg(RegRootW2, r[127:64]);
    write_reg(RegRootW3, r[63:0]);
  endtask

  // Waits until every predicted root word has been seen, then lets the block settle.
  task automatic drain();
    in_valid <= 1'b0;
    while (roots_owed != 0) @(negedge clk_i);
    repeat (SettleCycles) @(negedge clk_i);
  endtask

  // Mostly small sets, some scrambled digests and now and then a lone stray word.
  task automatic random_traffic(input int unsigned items);
    int unsigned goal, n;
    goal = sent_items + items;
    while (sent_items < goal) begin
      case ($urandom_range(9))
        0: send_scrambled(1'($urandom_range(1)));
        1: send_word({$urandom, $urandom}, 2'($urandom_range(2)), 1'($urandom_range(1)));
        2: send_set($urandom_range(12, 7));
        default: begin
          n = $urandom_range(6, 1);
          send_set(n);
        end
      endcase
    end
  endtask

  initial begin
    repeat (8) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Expected root at its upper extreme; writes past the last register are ignored.
    write_root({256{1'b1}});
    write_reg(RegNone, {$urandom, $urandom});
    write_reg(RegTop, {$urandom, $urandom});

    // Directed: single leaf of zeros, a pair of extreme digests, an odd set of three.
    send_digest('0, 1'b1);
    send_digest({256{1'b1}}, 1'b0);
    send_digest('0, 1'b1);
    send_digest({64'h0123456789abcdef, 64'hfedcba9876543210, {64{1'b1}}, 64'd0}, 1'b0);
    send_digest({4{64'h5555aaaa5555aaaa}}, 1'b0);
    send_digest({4{64'haaaa5555aaaa5555}}, 1'b1);

    // The receiver holds off while a few sets are offered, so the block backs up.
    hold_req++;
    random_traffic(40);
    drain();

    // Program the last root seen and replay its set: the match flag must rise.
    send_idle_pct = 47;
    recv_idle_pct = 10;
    write_root(seen_root);
    foreach (prev_set[i]) send_digest(prev_set[i], i == prev_set.size() - 1);
    // One set past capacity, so leaves are dropped.
    send_set(Capacity + 2);
    drain();

    write_root('0);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    random_traffic(30);
    drain();

    if (fail_count == 0) begin
      $display("testbench: done, clean");
    end else begin
      $display("testbench: done, errors");
    end
    $finish;
  end

endmodule
